>>> rtl/core/assert_macros.svh
// Assertion helpers for the conditioning module.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Temporal property, checked out of reset
`define JTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Invariant that must hold at every clock edge out of reset
`define JTC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

>>> rtl/core/jtc_pkg.sv
package jtc_pkg;

    // Axis lanes, in the order of the sample fields
    localparam int AXES   = 4;
    localparam int AX_THR = 0;
    localparam int AX_YAW = 1;
    localparam int AX_PIT = 2;
    localparam int AX_ROL = 3;

    // Field and state widths
    localparam int OUT_W  = 10;
    localparam int KEY_W  = 3;
    localparam int TRIM_W = 11;
    localparam int OFS_W  = 12;

    // Scaling and limits
    localparam int FULL_SCALE   = 1000;
    localparam int CENTRE_MID   = 500;
    localparam int TRIM_STEP    = 10;
    localparam int TRIM_LIMIT   = 1000;
    localparam int OFFSET_LIMIT = 2000;

    // Transaction kind
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_KEY    = 1'b1;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_PITCH_UP = 3'd0;
    localparam logic [KEY_W-1:0] KEY_PITCH_DN = 3'd1;
    localparam logic [KEY_W-1:0] KEY_ROLL_DN  = 3'd2;
    localparam logic [KEY_W-1:0] KEY_ROLL_UP  = 3'd3;
    localparam logic [KEY_W-1:0] KEY_SHUTDOWN = 3'd4;
    localparam logic [KEY_W-1:0] KEY_HOLD     = 3'd5;
    localparam logic [KEY_W-1:0] KEY_LONG     = 3'd6;

    typedef logic [OUT_W-1:0] axis_t;

    // Scaled transaction handed to the conditioning stage
    typedef struct packed {
        logic                   cmd;
        logic [KEY_W-1:0]       key;
        axis_t [AXES-1:0]       scaled;
    } jtc_item_t;

    // Result transaction
    typedef struct packed {
        axis_t [AXES-1:0]       axis;
        logic                   shutdown;
        logic                   hold;
    } jtc_result_t;

endpackage

>>> rtl/core/jtc_scale.sv
module jtc_scale
    import jtc_pkg::*;
#(
    parameter int ADC_BITS = 12,
    parameter bit INVERT   = 1'b0
)
(
    input  logic [ADC_BITS-1:0] raw,
    output axis_t               scaled
);

    // raw * 1000 fits in ADC_BITS + 10 bits
    localparam int T_W = ADC_BITS + 10;
    localparam int S_W = T_W + 1;
    localparam int Q_W = S_W - ADC_BITS;
    localparam logic [S_W-1:0] ADC_MAX = S_W'((1 << ADC_BITS) - 1);

    logic [T_W-1:0]   prod;
    logic [S_W-1:0]   sum_est;
    logic [Q_W-1:0]   q_est;
    logic [S_W-1:0]   rem;
    logic [Q_W-1:0]   q_fix;
    logic [OUT_W-1:0] q_out;

    // Divide by 2^n - 1 as a series of shifts; the estimate is at most one low
    always_comb
    begin
        // 1000 = 1024 - 16 - 8
        prod    = (T_W'(raw) << 10) - (T_W'(raw) << 4) - (T_W'(raw) << 3);
        sum_est = S_W'(prod) + S_W'(prod >> ADC_BITS) + S_W'(prod >> (2 * ADC_BITS));
        q_est   = Q_W'(sum_est >> ADC_BITS);
        // remainder = prod - q_est * (2^n - 1)
        rem     = S_W'(prod) + S_W'(q_est) - (S_W'(q_est) << ADC_BITS);
        q_fix   = (rem >= ADC_MAX) ? q_est + Q_W'(1) : q_est;
        q_out   = q_fix[OUT_W-1:0];
        scaled  = INVERT ? OUT_W'(FULL_SCALE) - q_out : q_out;
    end

endmodule

>>> rtl/core/jtc_cal_div.sv
module jtc_cal_div
    import jtc_pkg::*;
#(
    parameter int CAL_SAMPLES = 10,
    parameter int SUM_W       = 15
)
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [AXES-1:0][SUM_W-1:0]  sums,
    output logic [AXES-1:0][OFS_W-1:0]  quot
);

    // Reciprocal multiply, exact for every magnitude the window can reach
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_SHIFT = MAG_W + $clog2(CAL_SAMPLES + 1);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int RECIP     = ((1 << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic [AXES-1:0]              sign;
    logic [AXES-1:0][MAG_W-1:0]   mag;
    logic [AXES-1:0][PROD_W-1:0]  prod;
    logic [AXES-1:0][OFS_W-1:0]   qmag;
    logic [AXES-1:0][OFS_W-1:0]   quot_next;
    logic [AXES-1:0][OFS_W-1:0]   quot_reg;

    // Signed division truncating toward zero: divide the magnitude
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            sign[i]      = sums[i][SUM_W-1];
            mag[i]       = sign[i] ? MAG_W'(-sums[i]) : MAG_W'(sums[i]);
            prod[i]      = PROD_W'(mag[i]) * PROD_W'(RECIP_V);
            qmag[i]      = OFS_W'(prod[i] >> DIV_SHIFT);
            quot_next[i] = sign[i] ? -qmag[i] : qmag[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

>>> rtl/core/jtc_cond.sv
`include "assert_macros.svh"

module jtc_cond
    import jtc_pkg::*;
#(
    parameter int CAL_SAMPLES = 10,
    parameter int SUM_W       = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  jtc_item_t   item,
    input  logic        item_valid,
    output logic        item_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output jtc_result_t result
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int V_W   = OFS_W + 2;
    localparam int OW1   = OFS_W + 1;

    // Offset update sequencer
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;

    logic [1:0]                 phase_reg;
    logic signed [OFS_W-1:0]    ofs_reg [AXES];
    logic signed [TRIM_W-1:0]   trim_reg [2];
    logic [SUM_W-1:0]           sum_reg [AXES];
    logic [CNT_W-1:0]           cnt_reg;
    logic                       active_reg;
    logic                       shut_reg;
    logic                       hold_reg;
    logic                       out_valid_reg;
    jtc_result_t                res_reg;

    logic                       take;
    logic                       take_sample;
    logic                       take_key;
    logic signed [V_W-1:0]      v_raw [AXES];
    axis_t                      v_clamp [AXES];
    logic [SUM_W-1:0]           sum_next [AXES];
    logic [SUM_W-1:0]           centre_val [AXES];
    logic [CNT_W-1:0]           cnt_next;
    logic [AXES-1:0][SUM_W-1:0] sum_bus;
    logic [AXES-1:0][OFS_W-1:0] quot_bus;
    logic signed [OW1-1:0]      ofs_sum [AXES];

    // Step a trim by one notch and hold it inside its limits
    function automatic logic signed [TRIM_W-1:0] trim_step(
        input logic signed [TRIM_W-1:0] t,
        input logic                     up
    );
        logic signed [TRIM_W:0] w;
        w = up ? (TRIM_W+1)'(t) + (TRIM_W+1)'(TRIM_STEP)
               : (TRIM_W+1)'(t) - (TRIM_W+1)'(TRIM_STEP);
        if (w > TRIM_LIMIT)
            return TRIM_W'(TRIM_LIMIT);
        else if (w < -TRIM_LIMIT)
            return TRIM_W'(-TRIM_LIMIT);
        else
            return w[TRIM_W-1:0];
    endfunction

    // Key transactions need no output slot; samples need a free one
    assign item_ready  = (phase_reg == PH_IDLE)
                         && ((item.cmd == CMD_KEY) || !out_valid_reg || !out_stall);
    assign take        = item_valid && item_ready;
    assign take_sample = take && (item.cmd == CMD_SAMPLE);
    assign take_key    = take && (item.cmd == CMD_KEY);
    assign cnt_next    = cnt_reg + CNT_W'(1);

    // Offset, trim, clamp and window accumulation per axis
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            v_raw[i] = $signed(V_W'(item.scaled[i])) - V_W'(ofs_reg[i]);
            if (i == AX_PIT)
                v_raw[i] = v_raw[i] + V_W'(trim_reg[0]);
            else if (i == AX_ROL)
                v_raw[i] = v_raw[i] + V_W'(trim_reg[1]);

            if (v_raw[i] < 0)
                v_clamp[i] = '0;
            else if (v_raw[i] > FULL_SCALE)
                v_clamp[i] = OUT_W'(FULL_SCALE);
            else
                v_clamp[i] = v_raw[i][OUT_W-1:0];

            centre_val[i] = (i == AX_THR) ? '0 : SUM_W'(CENTRE_MID);
            sum_next[i]   = sum_reg[i] + SUM_W'(v_clamp[i]) - centre_val[i];
            sum_bus[i]    = sum_reg[i];
            ofs_sum[i]    = OW1'(ofs_reg[i]) + OW1'($signed(quot_bus[i]));
        end
    end

    jtc_cal_div #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_div (
        .clk  (clk),
        .load (phase_reg == PH_DIV),
        .sums (sum_bus),
        .quot (quot_bus)
    );

    // Trims, flags, calibration window and offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            shut_reg   <= 1'b0;
            hold_reg   <= 1'b0;
            trim_reg[0] <= '0;
            trim_reg[1] <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                ofs_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (take_key)
                    begin
                        unique case (item.key)
                            KEY_PITCH_UP: trim_reg[0] <= trim_step(trim_reg[0], 1'b1);
                            KEY_PITCH_DN: trim_reg[0] <= trim_step(trim_reg[0], 1'b0);
                            KEY_ROLL_DN:  trim_reg[1] <= trim_step(trim_reg[1], 1'b0);
                            KEY_ROLL_UP:  trim_reg[1] <= trim_step(trim_reg[1], 1'b1);
                            KEY_SHUTDOWN: shut_reg <= 1'b1;
                            KEY_HOLD:     hold_reg <= 1'b1;
                            KEY_LONG:
                            begin
                                trim_reg[0] <= '0;
                                trim_reg[1] <= '0;
                                cnt_reg     <= '0;
                                active_reg  <= 1'b1;
                                for (int i = 0; i < AXES; i++)
                                begin
                                    sum_reg[i] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (take_sample && active_reg)
                    begin
                        cnt_reg <= cnt_next;
                        for (int i = 0; i < AXES; i++)
                        begin
                            sum_reg[i] <= sum_next[i];
                        end
                        if (cnt_next >= CNT_W'(CAL_SAMPLES))
                            phase_reg <= PH_DIV;
                    end
                end
                PH_DIV:
                begin
                    phase_reg <= PH_ADD;
                end
                PH_ADD:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        if (ofs_sum[i] > OFFSET_LIMIT)
                            ofs_reg[i] <= OFS_W'(OFFSET_LIMIT);
                        else if (ofs_sum[i] < -OFFSET_LIMIT)
                            ofs_reg[i] <= OFS_W'(-OFFSET_LIMIT);
                        else
                            ofs_reg[i] <= ofs_sum[i][OFS_W-1:0];
                        sum_reg[i] <= '0;
                    end
                    cnt_reg    <= '0;
                    active_reg <= 1'b0;
                    phase_reg  <= PH_IDLE;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take_sample)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                res_reg.axis[i] <= v_clamp[i];
            end
            res_reg.shutdown <= shut_reg;
            res_reg.hold     <= hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    `JTC_ASSERT(a_div_then_add, (phase_reg == PH_DIV) |=> (phase_reg == PH_ADD), "offset update skipped its add step")
    `JTC_ASSERT(a_window_closes, (phase_reg == PH_ADD) |=> (!active_reg && (cnt_reg == '0) && (phase_reg == PH_IDLE)), "calibration window left open after offset update")
    `JTC_ASSERT_ALWAYS(a_count_outside_window, active_reg || (cnt_reg == '0), "sample count moved outside a window")
    `JTC_ASSERT_ALWAYS(a_trim_range, (trim_reg[0] <= TRIM_LIMIT) && (trim_reg[0] >= -TRIM_LIMIT) && (trim_reg[1] <= TRIM_LIMIT) && (trim_reg[1] >= -TRIM_LIMIT), "trim beyond its limit")

endmodule

>>> rtl/core/joystick_trim_calibrate_conditioner.sv
// Joystick conditioner: four stick readings in, four 0..1000 values out.
// Input channel (in_valid / in_stall): cmd = 0 carries a stick sample in
// thr_raw..rol_raw, cmd = 1 carries a key event in key_code. Key events
// produce no result; they step the pitch/roll trims, set the sticky
// shutdown and hold-height flags, or (long press) clear the trims and open a
// calibration window of CAL_SAMPLES samples.
// Output channel (out_valid / out_stall): one transaction per sample.
// A sample accepted into the input register moves on through the scaling
// register and the result register before out_valid presents it.
// Throughput is one transaction per cycle while out_stall is low and no
// offset update runs; the scaling lanes are combinational.
// The sample that closes a calibration window is followed by the divide
// and add phases, in which the conditioning stage takes nothing while the
// offsets are updated; the input keeps filling its two registers meanwhile.
// While out_stall is high the result is held and the two front registers
// can still take transactions, then in_stall rises.
// Reset clears offsets, trims, window state, flags and all valid bits.
module joystick_trim_calibrate_conditioner
    import jtc_pkg::*;
#(
    parameter int CAL_SAMPLES = 10,
    parameter int ADC_BITS    = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [ADC_BITS-1:0] thr_raw,
    input  logic [ADC_BITS-1:0] yaw_raw,
    input  logic [ADC_BITS-1:0] pit_raw,
    input  logic [ADC_BITS-1:0] rol_raw,
    input  logic [KEY_W-1:0]    key_code,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_W-1:0]    thr_out,
    output logic [OUT_W-1:0]    yaw_out,
    output logic [OUT_W-1:0]    pit_out,
    output logic [OUT_W-1:0]    rol_out,
    output logic                shutdown_flag,
    output logic                hold_height_flag
);

    // Window sum holds +-FULL_SCALE * CAL_SAMPLES
    localparam int SUM_W = $clog2(FULL_SCALE * CAL_SAMPLES + 1) + 1;

    logic                a_valid_reg;
    logic                a_cmd_reg;
    logic [KEY_W-1:0]    a_key_reg;
    logic [ADC_BITS-1:0] a_raw_reg [AXES];
    logic                b_valid_reg;
    jtc_item_t           b_item_reg;
    jtc_item_t           b_item_next;

    logic                cond_ready;
    logic                b_take;
    logic                b_free;
    logic                a_move;
    logic                a_free;
    logic                in_take;
    jtc_result_t         result;

    // Stage handshakes
    assign b_take   = b_valid_reg && cond_ready;
    assign b_free   = !b_valid_reg || cond_ready;
    assign a_move   = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || b_free;
    assign in_take  = in_valid && a_free;
    assign in_stall = !a_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_take)
            a_valid_reg <= 1'b1;
        else if (a_move)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_cmd_reg         <= cmd;
            a_key_reg         <= key_code;
            a_raw_reg[AX_THR] <= thr_raw;
            a_raw_reg[AX_YAW] <= yaw_raw;
            a_raw_reg[AX_PIT] <= pit_raw;
            a_raw_reg[AX_ROL] <= rol_raw;
        end
    end

    // Scaling lanes; yaw and roll are inverted
    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        jtc_scale #(
            .ADC_BITS (ADC_BITS),
            .INVERT   ((i == AX_YAW) || (i == AX_ROL))
        ) u_scale (
            .raw    (a_raw_reg[i]),
            .scaled (b_item_next.scaled[i])
        );
    end

    assign b_item_next.cmd = a_cmd_reg;
    assign b_item_next.key = a_key_reg;

    // Scaled register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (a_move)
            b_valid_reg <= 1'b1;
        else if (b_take)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
            b_item_reg <= b_item_next;
    end

    jtc_cond #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_cond (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (b_item_reg),
        .item_valid (b_valid_reg),
        .item_ready (cond_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign thr_out          = result.axis[AX_THR];
    assign yaw_out          = result.axis[AX_YAW];
    assign pit_out          = result.axis[AX_PIT];
    assign rol_out          = result.axis[AX_ROL];
    assign shutdown_flag    = result.shutdown;
    assign hold_height_flag = result.hold;

endmodule
